// ----- sv/pnd2_pkg.sv -----
package pnd2_pkg;

	// Default configuration
	localparam int FRAC_BITS_DEF     = 16;
	localparam int ANGLE_BITS_DEF    = 10;
	localparam int OUT_FRAC_BITS_DEF = 15;
	localparam int QUEUE_DEPTH       = 4;

	// Corner hash multipliers
	localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

	// pi/2 in Q2.30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Gradient quadrant, top two bits of the angle
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Swap the 16-bit halves of a word
	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// Clamp a Q2.30 value to [0, 1], round half up to Q1.15, saturate
	function automatic logic [15:0] to_q15(input longint v);
		longint c;
		longint q;
		c = v;
		if (c < 0) c = 0;
		if (c > (longint'(1) <<< 30)) c = longint'(1) <<< 30;
		q = (c + 16384) >>> 15;
		if (q > 32767) q = 32767;
		return q[15:0];
	endfunction

	// Quarter-wave sine and cosine of entry r, packed as {sin, cos} in Q1.15
	function automatic logic [31:0] quarter_sincos(input int r, input int ab);
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		longint ss;
		longint cs;
		theta = (64'(r) * HALF_PI_Q30) >> (ab - 2);
		x2 = (theta * theta) >> 30;
		ts = theta;
		tc = 64'd1 << 30;
		ss = longint'(theta);
		cs = longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd6;
		tc = ((tc * x2) >> 30) / 64'd2;
		ss = ss - longint'(ts);
		cs = cs - longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd20;
		tc = ((tc * x2) >> 30) / 64'd12;
		ss = ss + longint'(ts);
		cs = cs + longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd42;
		tc = ((tc * x2) >> 30) / 64'd30;
		ss = ss - longint'(ts);
		cs = cs - longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd72;
		tc = ((tc * x2) >> 30) / 64'd56;
		ss = ss + longint'(ts);
		cs = cs + longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd110;
		tc = ((tc * x2) >> 30) / 64'd90;
		ss = ss - longint'(ts);
		cs = cs - longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd156;
		tc = ((tc * x2) >> 30) / 64'd132;
		ss = ss + longint'(ts);
		cs = cs + longint'(tc);
		ts = ((ts * x2) >> 30) / 64'd210;
		tc = ((tc * x2) >> 30) / 64'd182;
		ss = ss - longint'(ts);
		cs = cs - longint'(tc);
		return {to_q15(ss), to_q15(cs)};
	endfunction

endpackage

// ----- sv/pnd2_front.sv -----
module pnd2_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [31:0]            x_coord,
	input  logic signed [31:0]            y_coord,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic [4*32+2*FRAC_BITS-1:0]   push_data
);
	import pnd2_pkg::*;

	logic [31:0] x0_c;
	logic [31:0] y0_c;
	logic        valid_s1;
	logic [31:0] x0_s1;
	logic [31:0] x1_s1;
	logic [31:0] y0_s1;
	logic [31:0] y1_s1;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [FRAC_BITS-1:0] fy_s1;

	// Cell by floor: arithmetic shift rounds toward minus infinity
	assign x0_c = 32'(x_coord >>> FRAC_BITS);
	assign y0_c = 32'(y_coord >>> FRAC_BITS);

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = {x0_s1, x1_s1, y0_s1, y1_s1, fx_s1, fy_s1};

	// Hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Split coordinates into cell corners and fractions
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x0_s1 <= x0_c;
			x1_s1 <= x0_c + 32'd1;
			y0_s1 <= y0_c;
			y1_s1 <= y0_c + 32'd1;
			fx_s1 <= x_coord[FRAC_BITS-1:0];
			fy_s1 <= y_coord[FRAC_BITS-1:0];
		end
	end

endmodule

// ----- sv/pnd2_queue.sv -----
module pnd2_queue #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import pnd2_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/pnd2_back.sv -----
module pnd2_back #(
	parameter int FRAC_BITS     = 16,
	parameter int ANGLE_BITS    = 10,
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  logic [4*32+2*FRAC_BITS-1:0] pop_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [15:0]          noise_value
);
	import pnd2_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int RB  = ANGLE_BITS - 2;
	localparam int QN  = 1 << RB;
	localparam int PW  = F + 16;
	localparam int DW  = PW + 1;
	localparam int XW  = DW + 1;
	localparam int MW  = XW + 18;
	localparam int SH  = F + 15 - OUT_FRAC_BITS;
	localparam int RW  = DW + 1;
	localparam int NST = 13;
	localparam logic signed [RW-1:0] HALF_LSB = RW'(64'd1 << (SH - 1));
	localparam logic signed [RW-1:0] SAT_HI   = RW'(32767);
	localparam logic signed [RW-1:0] SAT_LO   = -RW'(32768);

	// Gradient ROM, {sin, cos} per quarter-wave entry
	logic [31:0] rom [QN];
	for (genvar k = 0; k < QN; k++) begin : g_rom
		localparam logic [31:0] ENTRY = quarter_sincos(k, ANGLE_BITS);
		assign rom[k] = ENTRY;
	end

	logic [NST-1:0] vld_q;
	logic           en;

	logic [31:0]    x0_in, x1_in, y0_in, y1_in;
	logic [F-1:0]   fx_in, fy_in;

	// Stage 1
	logic [31:0]    ha_s1 [2];
	logic [31:0]    yc_s1 [2];
	logic [F-1:0]   fx_s1, fy_s1;
	// Stage 2
	logic [31:0]    ha_s2 [2];
	logic [31:0]    hb_s2 [4];
	logic [F-1:0]   fx_s2, fy_s2;
	logic [15:0]    wx_s2, wy_s2, w2x_s2, w2y_s2;
	logic [15:0]    wx_c, wy_c;
	logic [31:0]    sqx_c, sqy_c;
	// Stage 3
	logic [31:0]    hc_s3 [4];
	logic [F-1:0]   fx_s3, fy_s3;
	logic [16:0]    sx_s3, sy_s3;
	logic [33:0]    smx_c, smy_c;
	// Stage 4
	logic [31:0]    rom_s4 [4];
	logic [1:0]     quad_s4 [4];
	logic [F-1:0]   fx_s4, fy_s4;
	logic [16:0]    sx_s4, sy_s4;
	// Stage 5
	logic signed [15:0] gx_c [4];
	logic signed [15:0] gy_c [4];
	logic signed [F:0]  dx_c [4];
	logic signed [F:0]  dy_c [4];
	logic signed [PW-1:0] px_s5 [4];
	logic signed [PW-1:0] py_s5 [4];
	logic [16:0]    sx_s5, sy_s5;
	// Stage 6
	logic signed [DW-1:0] dot_s6 [4];
	logic [16:0]    sx_s6, sy_s6;
	// Stage 7
	logic signed [XW-1:0] db_s7, dt_s7;
	logic signed [DW-1:0] ab_s7, at_s7;
	logic [16:0]    sx_s7, sy_s7;
	// Stage 8
	logic signed [MW-1:0] pb_s8, pt_s8;
	logic signed [DW-1:0] ab_s8, at_s8;
	logic [16:0]    sy_s8;
	// Stage 9
	logic signed [DW-1:0] bot_s9, top_s9;
	logic [16:0]    sy_s9;
	// Stage 10
	logic signed [XW-1:0] dv_s10;
	logic signed [DW-1:0] bot_s10;
	logic [16:0]    sy_s10;
	// Stage 11
	logic signed [MW-1:0] pv_s11;
	logic signed [DW-1:0] bot_s11;
	// Stage 12
	logic signed [DW-1:0] v_s12;
	// Stage 13
	logic signed [RW-1:0] rnd_c;
	logic signed [RW-1:0] rsh_c;
	logic signed [15:0]   noise_s13;

	assign {x0_in, x1_in, y0_in, y1_in, fx_in, fy_in} = pop_data;

	// Whole pipe moves when the output register is free or draining
	assign en          = !vld_q[NST-1] || out_ready;
	assign pop_ready   = en;
	assign out_valid   = vld_q[NST-1];
	assign noise_value = noise_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pop_valid};
		end
	end

	// Fraction to Q.16 weight input
	if (F >= 16) begin : g_wdown
		assign wx_c = fx_s1[F-1 -: 16];
		assign wy_c = fy_s1[F-1 -: 16];
	end else begin : g_wup
		assign wx_c = {fx_s1, (16 - F)'(0)};
		assign wy_c = {fy_s1, (16 - F)'(0)};
	end

	assign sqx_c = 32'(wx_c) * 32'(wx_c);
	assign sqy_c = 32'(wy_c) * 32'(wy_c);
	assign smx_c = 34'(18'(18'd196608 - {1'b0, wx_s2, 1'b0})) * 34'(w2x_s2);
	assign smy_c = 34'(18'(18'd196608 - {1'b0, wy_s2, 1'b0})) * 34'(w2y_s2);

	// Apply the gradient quadrant and form corner offsets
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			unique case (quad_t'(quad_s4[c]))
				QUAD_0: begin
					gx_c[c] = $signed(rom_s4[c][15:0]);
					gy_c[c] = $signed(rom_s4[c][31:16]);
				end
				QUAD_1: begin
					gx_c[c] = -$signed(rom_s4[c][31:16]);
					gy_c[c] = $signed(rom_s4[c][15:0]);
				end
				QUAD_2: begin
					gx_c[c] = -$signed(rom_s4[c][15:0]);
					gy_c[c] = -$signed(rom_s4[c][31:16]);
				end
				QUAD_3: begin
					gx_c[c] = $signed(rom_s4[c][31:16]);
					gy_c[c] = -$signed(rom_s4[c][15:0]);
				end
				default: begin
					gx_c[c] = '0;
					gy_c[c] = '0;
				end
			endcase
			dx_c[c] = (c % 2 == 1) ? $signed({1'b1, fx_s4}) : $signed({1'b0, fx_s4});
			dy_c[c] = (c / 2 == 1) ? $signed({1'b1, fy_s4}) : $signed({1'b0, fy_s4});
		end
	end

	// Round half up and saturate
	assign rnd_c = RW'(v_s12) + HALF_LSB;
	assign rsh_c = rnd_c >>> SH;

	always_ff @(posedge clk) begin
		if (en) begin
			// Hash first step per column
			ha_s1[0] <= 32'(x0_in * HASH_MUL_A);
			ha_s1[1] <= 32'(x1_in * HASH_MUL_A);
			yc_s1[0] <= y0_in;
			yc_s1[1] <= y1_in;
			fx_s1    <= fx_in;
			fy_s1    <= fy_in;

			// Hash second step per corner, weight square
			for (int c = 0; c < 4; c++) begin
				hb_s2[c] <= 32'((yc_s1[c / 2] ^ rot16(ha_s1[c % 2])) * HASH_MUL_B);
			end
			ha_s2  <= ha_s1;
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			wx_s2  <= wx_c;
			wy_s2  <= wy_c;
			w2x_s2 <= sqx_c[31:16];
			w2y_s2 <= sqy_c[31:16];

			// Hash last step, smoothstep weight
			for (int c = 0; c < 4; c++) begin
				hc_s3[c] <= 32'((ha_s2[c % 2] ^ rot16(hb_s2[c])) * HASH_MUL_C);
			end
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			sx_s3 <= smx_c[32:16];
			sy_s3 <= smy_c[32:16];

			// Gradient lookup
			for (int c = 0; c < 4; c++) begin
				rom_s4[c]  <= rom[hc_s3[c][29 -: RB]];
				quad_s4[c] <= hc_s3[c][31:30];
			end
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;

			// Dot product terms, operands widened to the product width
			for (int c = 0; c < 4; c++) begin
				px_s5[c] <= PW'(dx_c[c]) * PW'(gx_c[c]);
				py_s5[c] <= PW'(dy_c[c]) * PW'(gy_c[c]);
			end
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;

			for (int c = 0; c < 4; c++) begin
				dot_s6[c] <= DW'(px_s5[c]) + DW'(py_s5[c]);
			end
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;

			// Blend along x
			db_s7 <= XW'(dot_s6[1]) - XW'(dot_s6[0]);
			dt_s7 <= XW'(dot_s6[3]) - XW'(dot_s6[2]);
			ab_s7 <= dot_s6[0];
			at_s7 <= dot_s6[2];
			sx_s7 <= sx_s6;
			sy_s7 <= sy_s6;

			pb_s8 <= MW'(db_s7) * MW'($signed({1'b0, sx_s7}));
			pt_s8 <= MW'(dt_s7) * MW'($signed({1'b0, sx_s7}));
			ab_s8 <= ab_s7;
			at_s8 <= at_s7;
			sy_s8 <= sy_s7;

			bot_s9 <= DW'(XW'(ab_s8) + XW'(pb_s8 >>> 16));
			top_s9 <= DW'(XW'(at_s8) + XW'(pt_s8 >>> 16));
			sy_s9  <= sy_s8;

			// Blend along y
			dv_s10  <= XW'(top_s9) - XW'(bot_s9);
			bot_s10 <= bot_s9;
			sy_s10  <= sy_s9;

			pv_s11  <= MW'(dv_s10) * MW'($signed({1'b0, sy_s10}));
			bot_s11 <= bot_s10;

			v_s12 <= DW'(XW'(bot_s11) + XW'(pv_s11 >>> 16));

			// Output register
			if (rsh_c > SAT_HI) begin
				noise_s13 <= 16'sd32767;
			end else if (rsh_c < SAT_LO) begin
				noise_s13 <= -16'sd32768;
			end else begin
				noise_s13 <= 16'(rsh_c);
			end
		end
	end

endmodule

// ----- sv/perlin_noise_2d_eval_unit.sv -----
// 2D gradient noise, one sample per beat.
// Path from input beat to result valid with an empty queue: front register, queue,
// 13-stage evaluation pipe ending in the output register.
// Throughput: one sample per cycle while out_ready stays high.
// Reset: arst_n clears the front, queue and pipeline valid state; payload is not reset.
module perlin_noise_2d_eval_unit #(
	parameter int FRAC_BITS     = pnd2_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS    = pnd2_pkg::ANGLE_BITS_DEF,
	parameter int OUT_FRAC_BITS = pnd2_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);
	import pnd2_pkg::*;

	localparam int QW = 4 * 32 + 2 * FRAC_BITS;

	logic          push_valid;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [QW-1:0] pop_data;

	pnd2_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	pnd2_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	pnd2_back #(
		.FRAC_BITS    (FRAC_BITS),
		.ANGLE_BITS   (ANGLE_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.noise_value(noise_value)
	);

endmodule

// ----- sv/pnd2_checker.sv -----
module pnd2_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] noise_value
);
	import pnd2_pkg::*;

	// Front register, queue and pipe stages
	localparam int MAX_ITEMS = 1 + QUEUE_DEPTH + 13;

	logic [5:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Track items inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat && !out_beat) begin
			cnt_q <= cnt_q + 6'd1;
		end else if (out_beat && !in_beat) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 6'd0)
		else $error("result without a pending sample");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> cnt_q != 6'd0)
		else $error("input stalled while empty");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'(MAX_ITEMS))
		else $error("more samples in flight than storage");

endmodule

bind perlin_noise_2d_eval_unit pnd2_checker u_pnd2_checker (.*);

// ----- dv/perlin_noise_2d_eval_unit_test.sv -----
module perlin_noise_2d_eval_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pnd2_pkg::*;

	localparam int FB  = FRAC_BITS_DEF;
	localparam int AB  = ANGLE_BITS_DEF;
	localparam int OFB = OUT_FRAC_BITS_DEF;
	localparam int LATENCY = 15;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] noise_value;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} sample_t;

	sample_t pending_samples[$];
	logic signed [15:0] expected_noise[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	perlin_noise_2d_eval_unit u_top (.*);

	always #5 clk = ~clk;

	// floor(v / 2^n) for signed values
	function automatic longint floor_div(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic longint clamp_q15(input longint v);
		longint q;
		if (v < 0) v = 0;
		if (v > (longint'(1) << 30)) v = longint'(1) << 30;
		q = (v + 16384) >>> 15;
		return (q > 32767) ? 32767 : q;
	endfunction

	// Gradient angle table entry r within one quarter
	function automatic void sincos_entry(input int r, output longint s, output longint c);
		logic [63:0] theta, x2, ts, tc;
		longint ss, cs;
		theta = (64'(r) * 64'd1686629713) >> (AB - 2);
		x2 = (theta * theta) >> 30;
		ts = theta;
		tc = 64'd1 << 30;
		ss = longint'(theta);
		cs = longint'(tc);
		for (int n = 1; n <= 7; n++) begin
			ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				ss -= longint'(ts);
				cs -= longint'(tc);
			end else begin
				ss += longint'(ts);
				cs += longint'(tc);
			end
		end
		s = clamp_q15(ss);
		c = clamp_q15(cs);
	endfunction

	function automatic longint gradient_dot(input logic [31:0] cx, input logic [31:0] cy,
			input longint dx, input longint dy);
		logic [31:0] a, b;
		int k, r;
		quad_t q;
		longint s, c, gx, gy;
		a = cx * HASH_MUL_A;
		b = cy ^ {a[15:0], a[31:16]};
		b = b * HASH_MUL_B;
		a = a ^ {b[15:0], b[31:16]};
		a = a * HASH_MUL_C;
		k = int'(a >> (32 - AB));
		q = quad_t'(2'((k >> (AB - 2)) & 3));
		r = k & ((1 << (AB - 2)) - 1);
		sincos_entry(r, s, c);
		case (q)
			QUAD_0: begin gx = c;  gy = s;  end
			QUAD_1: begin gx = -s; gy = c;  end
			QUAD_2: begin gx = -c; gy = -s; end
			default: begin gx = s; gy = -c; end
		endcase
		return dx * gx + dy * gy;
	endfunction

	function automatic longint fade_weight(input longint f);
		longint w, w2;
		w = (FB >= 16) ? (f >> (FB - 16)) : (f << (16 - FB));
		w2 = (w * w) >> 16;
		return (((longint'(3) << 16) - 2 * w) * w2) >> 16;
	endfunction

	function automatic longint lerp_fade(input longint a0, input longint a1, input longint s);
		return a0 + floor_div((a1 - a0) * s, 16);
	endfunction

	function automatic logic signed [15:0] noise_at(input sample_t p);
		longint sx, sy, fx, fy, one, wx, wy, dx1, dy1, bot, top, v, r;
		logic [31:0] x0, y0;
		int sh;
		sx = longint'(p.x);
		sy = longint'(p.y);
		one = longint'(1) << FB;
		fx = sx & (one - 1);
		fy = sy & (one - 1);
		x0 = 32'(floor_div(sx, FB));
		y0 = 32'(floor_div(sy, FB));
		dx1 = fx - one;
		dy1 = fy - one;
		wx = fade_weight(fx);
		wy = fade_weight(fy);
		bot = lerp_fade(gradient_dot(x0, y0, fx, fy), gradient_dot(x0 + 1, y0, dx1, fy), wx);
		top = lerp_fade(gradient_dot(x0, y0 + 1, fx, dy1),
			gradient_dot(x0 + 1, y0 + 1, dx1, dy1), wx);
		v = lerp_fade(bot, top, wy);
		sh = FB + 15 - OFB;
		r = floor_div(v + (longint'(1) << (sh - 1)), sh);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 2 << FB)) - (1 << FB));
			2: return 32'(int'($urandom_range(0, 64 << FB)) - (32 << FB));
			default: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom)};
		endcase
	endfunction

	// Sender: present a new beat or hold the current one
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					sample_t p;
					p = pending_samples.pop_front();
					x_coord <= p.x;
					y_coord <= p.y;
					in_valid <= 1'b1;
					expected_noise.insert(expected_noise.size(), noise_at(p));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result beat, then choose next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_noise.size() == 0) begin
					$error("noise_value: unexpected beat, actual %0d", noise_value);
					fail_count++;
				end else begin
					logic signed [15:0] e;
					e = expected_noise.pop_front();
					if (e !== noise_value) begin
						$error("noise_value: expected %0d, actual %0d", e, noise_value);
						fail_count++;
					end
				end
			end
			out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver stall so the queue fills and in_ready drops
	initial begin
		int n;
		n = 0;
		wait (arst_n);
		repeat (200) @(posedge clk);
		hold_off = 1'b1;
		while (n < 60) begin
			@(posedge clk);
			n++;
		end
		hold_off = 1'b0;
	end

	task automatic add_samples(input int count);
		sample_t p;
		repeat (count) begin
			p.x = rand_coord();
			p.y = rand_coord();
			pending_samples.insert(pending_samples.size(), p);
		end
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !in_valid);
		wait (expected_noise.size() == 0);
	endtask

	initial begin
		logic signed [31:0] corners[8];
		corners = '{32'sh0, 32'sh7FFFFFFF, 32'sh80000000, 32'shFFFFFFFF,
			32'sh00010000, 32'shFFFF0000, 32'sh00008000, 32'shFFFF8000};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// Extremes, negative cells and wraparound at the top edge
		foreach (corners[i])
			pending_samples.insert(pending_samples.size(),
				sample_t'{corners[i], corners[(i + 3) % 8]});
		for (int i = 0; i < 8; i++)
			pending_samples.insert(pending_samples.size(), sample_t'{corners[i], corners[i]});
		pending_samples.insert(pending_samples.size(), sample_t'{32'sh7FFFFFFF, 32'sh7FFF0001});
		pending_samples.insert(pending_samples.size(), sample_t'{-32'sd5, 32'sd5});
		send_idle_pct = 32;
		recv_idle_pct = 83;
		add_samples(500);
		drain();
		send_idle_pct = 83;
		recv_idle_pct = 32;
		add_samples(500);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_samples(500);
		drain();
		repeat (LATENCY * 2) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pnd2_pkg.sv
sv/pnd2_front.sv
sv/pnd2_queue.sv
sv/pnd2_back.sv
sv/perlin_noise_2d_eval_unit.sv
sv/pnd2_checker.sv
dv/perlin_noise_2d_eval_unit_test.sv
